[hw/rtl/tlv_option_remover_core_macros.svh]
// ----------------------------------------------------------------------------
// TLV option remover - assertion macros
// Shared property wrappers; all expect clk in scope, the first two also rst.
// ----------------------------------------------------------------------------
`ifndef TLV_OPTION_REMOVER_CORE_MACROS_SVH
`define TLV_OPTION_REMOVER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define TLVR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TLVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define TLVR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tlvr_pkg.sv]
// ----------------------------------------------------------------------------
// TLV option remover - package
// Constants, status codes and the result item types.
// ----------------------------------------------------------------------------
package tlvr_pkg;

  localparam int HDR_BYTES       = 4;
  localparam int MAX_PUSH        = 5;   // 4 held header bytes + status
  localparam int PUSH_W          = $clog2(MAX_PUSH + 1);
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic [15:0] REMOVE_CODE_RST = 16'd8;

  localparam logic [1:0] ST_REMOVED   = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic [1:0]  status;
    logic [15:0] new_length;
    logic        end_of_run;
  } tlvr_item_t;

  typedef struct packed {
    logic [PUSH_W-1:0]                n;
    tlvr_item_t [MAX_PUSH-1:0]        items;
  } tlvr_push_t;

endpackage

[hw/rtl/tlvr_if.sv]
// ----------------------------------------------------------------------------
// TLV option remover - channel interfaces
// Valid/ready channels for bytes in, results out and the config write.
// ----------------------------------------------------------------------------
interface tlvr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tlvr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic [1:0]  status;
  logic [15:0] new_length;
  logic        end_of_run;

  modport source (output valid, output out_byte, output byte_valid, output status,
                  output new_length, output end_of_run, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input status,
                  input new_length, input end_of_run, output ready);
endinterface

interface tlvr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] remove_code;

  modport source (output valid, output remove_code, input ready);
  modport sink   (input valid, input remove_code, output ready);
endinterface

[hw/rtl/tlvr_parser.sv]
// ----------------------------------------------------------------------------
// TLV option remover - option parser
// Input register plus the per-byte option state machine; yields 0..5 items.
// ----------------------------------------------------------------------------
module tlvr_parser import tlvr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic        room,
  input  logic [15:0] remove_code,
  output tlvr_push_t  push
);

  typedef enum logic [1:0] {PH_HEADER, PH_KEEP, PH_DROP, PH_PASS} phase_t;

  // input register
  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_last;

  // option state
  phase_t      phase, phase_next;
  logic [23:0] header_hold, header_hold_next;
  logic [1:0]  header_count, header_count_next;
  logic [15:0] payload_left, payload_left_next;
  logic [15:0] byte_total, byte_total_next;
  logic [16:0] removed_size, removed_size_next;
  logic        removed_flag, removed_flag_next;

  logic              fire;
  logic [31:0]       hold_full;
  logic [15:0]       opt_code, opt_len, pl_dec;
  logic [2:0]        emit_cnt;
  logic              emit_byte;
  logic [PUSH_W-1:0] n;
  logic [1:0]        sh;
  tlvr_item_t [MAX_PUSH-1:0] items;

  assign fire     = hold_valid & room;
  assign in_ready = ~rst & (~hold_valid | room);

  always_comb begin
    phase_next        = phase;
    header_hold_next  = header_hold;
    header_count_next = header_count;
    payload_left_next = payload_left;
    byte_total_next   = byte_total + 16'd1;
    removed_size_next = removed_size;
    removed_flag_next = removed_flag;
    hold_full         = {header_hold, hold_byte};
    opt_code          = hold_full[31:16];
    opt_len           = hold_full[15:0];
    pl_dec            = payload_left - 16'd1;
    emit_cnt          = 3'd0;
    emit_byte         = 1'b0;
    items             = '0;
    n                 = '0;
    sh                = '0;

    unique case (phase)
      PH_HEADER: begin
        if (header_count == 2'd3) begin
          payload_left_next = opt_len;
          if (opt_code == remove_code) begin
            removed_flag_next = 1'b1;
            removed_size_next = {1'b0, opt_len} + 17'(HDR_BYTES);
            phase_next        = (opt_len != 16'd0) ? PH_DROP : PH_PASS;
          end else begin
            emit_cnt   = 3'(HDR_BYTES);
            phase_next = (opt_len != 16'd0) ? PH_KEEP : PH_HEADER;
          end
          header_count_next = '0;
          header_hold_next  = '0;
        end else begin
          header_hold_next  = hold_full[23:0];
          header_count_next = header_count + 2'd1;
          // short tail: flush what has been held so far
          if (hold_last) begin
            emit_cnt = {1'b0, header_count} + 3'd1;
          end
        end
      end
      PH_KEEP: begin
        emit_byte         = 1'b1;
        payload_left_next = pl_dec;
        if (pl_dec == 16'd0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_DROP: begin
        payload_left_next = pl_dec;
        if (pl_dec == 16'd0) begin
          phase_next = PH_PASS;
        end
      end
      PH_PASS: begin
        emit_byte = 1'b1;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase

    // held header bytes, oldest first
    for (int k = 0; k < HDR_BYTES; k++) begin
      if (3'(k) < emit_cnt) begin
        sh                    = 2'(emit_cnt - 3'd1 - 3'(k));
        items[k].out_byte     = 8'(hold_full >> {sh, 3'b000});
        items[k].byte_valid   = 1'b1;
      end
    end
    n = PUSH_W'(emit_cnt);

    if (emit_byte) begin
      items[n].out_byte   = hold_byte;
      items[n].byte_valid = 1'b1;
      n                   = n + 1'b1;
    end

    if (hold_last) begin
      items[n].end_of_run = 1'b1;
      if (phase_next == PH_KEEP || phase_next == PH_DROP) begin
        items[n].status     = ST_MALFORMED;
        items[n].new_length = byte_total_next;
      end else if (removed_flag_next) begin
        items[n].status     = ST_REMOVED;
        items[n].new_length = byte_total_next - removed_size_next[15:0];
      end else begin
        items[n].status     = ST_NOT_FOUND;
        items[n].new_length = byte_total_next;
      end
      n = n + 1'b1;
      // back to a clean run
      phase_next        = PH_HEADER;
      header_hold_next  = '0;
      header_count_next = '0;
      payload_left_next = '0;
      byte_total_next   = '0;
      removed_size_next = '0;
      removed_flag_next = 1'b0;
    end
  end

  assign push.n     = fire ? n : '0;
  assign push.items = items;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid   <= 1'b0;
      phase        <= PH_HEADER;
      header_hold  <= '0;
      header_count <= '0;
      payload_left <= '0;
      byte_total   <= '0;
      removed_size <= '0;
      removed_flag <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
        hold_byte  <= data_byte;
        hold_last  <= last_byte;
      end else if (fire) begin
        hold_valid <= 1'b0;
      end
      if (fire) begin
        phase        <= phase_next;
        header_hold  <= header_hold_next;
        header_count <= header_count_next;
        payload_left <= payload_left_next;
        byte_total   <= byte_total_next;
        removed_size <= removed_size_next;
        removed_flag <= removed_flag_next;
      end
    end
  end

endmodule

[hw/rtl/tlvr_out_queue.sv]
// ----------------------------------------------------------------------------
// TLV option remover - result queue
// Multi-push, single-pop queue; takes up to MAX_PUSH items per cycle.
// ----------------------------------------------------------------------------
module tlvr_out_queue import tlvr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  tlvr_push_t push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output tlvr_item_t out_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tlvr_item_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W:0]   wr_sum [MAX_PUSH];
  logic [PTR_W-1:0] wr_idx [MAX_PUSH];
  logic [PTR_W:0]   end_sum;
  logic [PTR_W-1:0] wr_ptr_next;
  logic             pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != '0);
  assign out_item  = mem[rd_ptr];
  assign room      = (count <= CNT_W'(DEPTH - MAX_PUSH));

  always_comb begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      wr_sum[i] = {1'b0, wr_ptr} + (PTR_W + 1)'(i);
      if (wr_sum[i] >= (PTR_W + 1)'(DEPTH)) begin
        wr_sum[i] = wr_sum[i] - (PTR_W + 1)'(DEPTH);
      end
      wr_idx[i] = wr_sum[i][PTR_W-1:0];
    end
    end_sum = {1'b0, wr_ptr} + (PTR_W + 1)'(push.n);
    if (end_sum >= (PTR_W + 1)'(DEPTH)) begin
      end_sum = end_sum - (PTR_W + 1)'(DEPTH);
    end
    wr_ptr_next = end_sum[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PUSH; i++) begin
      if (PUSH_W'(i) < push.n) begin
        mem[wr_idx[i]] <= push.items[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push.n) - CNT_W'(pop);
    end
  end

endmodule

[hw/rtl/tlv_option_remover_core.sv]
// ----------------------------------------------------------------------------
// TLV option remover - top level
// Streams an EDNS options area and drops the first option with a given code.
// ----------------------------------------------------------------------------
// Usage:
//   ingress carries one byte per transaction (data_byte, last_byte marks the
//   final byte of the area). egress carries kept bytes (byte_valid = 1) and,
//   after the final byte, one status transaction (end_of_run = 1) with the
//   status code and the new options length. cfg writes remove_code; write it
//   only while no run is in flight. Reset value of remove_code is 8.
// Path: an accepted byte waits in the parser's input register until the
//   queue has room; its results then go through the queue to egress.
// Throughput: one input byte per cycle unless egress stalls. An option
//   header yields nothing for three bytes and four held bytes on the fourth;
//   the queue absorbs that burst, so egress runs at one result per cycle.
// Stall: when egress is stalled the queue fills; ingress ready drops once
//   the queue has fewer than five free entries (worst case of one byte).
// Reset (synchronous, rst high): clears run state and queue, sets
//   remove_code to its reset value; ready is low while rst is high.
// ----------------------------------------------------------------------------
module tlv_option_remover_core import tlvr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // >= 8
) (
  input  logic clk,
  input  logic rst,
  tlvr_in_if.sink    ingress,
  tlvr_out_if.source egress,
  tlvr_cfg_if.sink   cfg
);

  logic [15:0] remove_code;
  logic        room;
  tlvr_push_t  push;
  tlvr_item_t  head;

  // config register; one write per transaction
  assign cfg.ready = ~rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      remove_code <= REMOVE_CODE_RST;
    end else if (cfg.valid && cfg.ready) begin
      remove_code <= cfg.remove_code;
    end
  end

  // parser: input register + option state machine
  tlvr_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (ingress.valid),
    .in_ready    (ingress.ready),
    .data_byte   (ingress.data_byte),
    .last_byte   (ingress.last_byte),
    .room        (room),
    .remove_code (remove_code),
    .push        (push)
  );

  // result queue decouples bursts from the egress side
  tlvr_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (egress.valid),
    .out_ready (egress.ready),
    .out_item  (head)
  );

  assign egress.out_byte   = head.out_byte;
  assign egress.byte_valid = head.byte_valid;
  assign egress.status     = head.status;
  assign egress.new_length = head.new_length;
  assign egress.end_of_run = head.end_of_run;

endmodule

[hw/rtl/tlvr_checker.sv]
// ----------------------------------------------------------------------------
// TLV option remover - port checker
// Watches the ingress and egress channels; bound onto the core.
// ----------------------------------------------------------------------------
`include "tlv_option_remover_core_macros.svh"

module tlvr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic [1:0]  status,
  input logic [15:0] new_length,
  input logic        end_of_run
);

  logic        in_acc, out_acc;
  logic [15:0] ends_pending;
  logic [31:0] bytes_pending;

  assign in_acc  = in_valid & in_ready;
  assign out_acc = out_valid & out_ready;

  // open runs and accepted bytes not yet seen on the output
  always_ff @(posedge clk) begin
    if (rst) begin
      ends_pending  <= '0;
      bytes_pending <= '0;
    end else begin
      ends_pending  <= ends_pending + 16'(in_acc & in_last)
                       - 16'(out_acc & end_of_run);
      bytes_pending <= bytes_pending + 32'(in_acc)
                       - 32'(out_acc & byte_valid);
    end
  end

  `TLVR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(status) && $stable(new_length) && $stable(end_of_run),
    "egress payload changed while stalled")
  `TLVR_ASSERT(a_status_has_run, out_acc && end_of_run, ends_pending != 16'd0,
    "status transaction without a finished input run")
  `TLVR_ASSERT(a_byte_has_source, out_acc && byte_valid, bytes_pending != 32'd0,
    "more output bytes than input bytes")
  `TLVR_ASSERT_RST(a_reset_empty, rst, !out_valid,
    "egress valid right after reset")

endmodule

bind tlv_option_remover_core tlvr_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (ingress.valid),
  .in_ready   (ingress.ready),
  .in_last    (ingress.last_byte),
  .out_valid  (egress.valid),
  .out_ready  (egress.ready),
  .out_byte   (egress.out_byte),
  .byte_valid (egress.byte_valid),
  .status     (egress.status),
  .new_length (egress.new_length),
  .end_of_run (egress.end_of_run)
);
